>>> rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int PID_W   = 8;
  localparam int SIZE_W  = 23;
  localparam int FS_W    = 17;
  localparam int CNT_W   = 7;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 17;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_FRAME_SIZE    = 8'd0;
  localparam logic [CIDX_W-1:0] REG_FRAMES_IN_USE = 8'd1;

  // Operation wave passed from cell to cell.
  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [PID_W-1:0]  pid;
    logic [SIZE_W-1:0] rem;   // allocation units still to cover
    logic [CNT_W-1:0]  fcnt;  // free managed frames seen so far
  } wave_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_PUSH
  } state_t;

endpackage

>>> rtl/pfa_in_if.sv
// ----------------------------------------------------------------------------
// pfa_in_if
// Request channel: allocate or release command with pid and size.
// ----------------------------------------------------------------------------
interface pfa_in_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [PID_W-1:0]  pid;
  logic [SIZE_W-1:0] size_needed;

  modport source (output valid, cmd, pid, size_needed, input ready);
  modport sink   (input valid, cmd, pid, size_needed, output ready);
endinterface

>>> rtl/pfa_out_if.sv
// ----------------------------------------------------------------------------
// pfa_out_if
// Result channel: status and free frame count.
// ----------------------------------------------------------------------------
interface pfa_out_if;
  import pfa_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [CNT_W-1:0] free_frames;

  modport source (output valid, ok, free_frames, input ready);
  modport sink   (input valid, ok, free_frames, output ready);
endinterface

>>> rtl/pfa_cfg_if.sv
// ----------------------------------------------------------------------------
// pfa_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface pfa_cfg_if;
  import pfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pfa_cell.sv
// ----------------------------------------------------------------------------
// pfa_cell
// One frame of the table: taken mark, owner, and one stage of the op wave.
// ----------------------------------------------------------------------------
module pfa_cell
  import pfa_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int OWN_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic [CNT_W-1:0] n_managed,
  input  logic [FS_W-1:0]  fs,
  input  wave_t            wave_i,
  output wave_t            wave_o
);

  logic             taken_r, taken_nxt;
  logic [OWN_W-1:0] owner_r, owner_nxt;
  wave_t            wave_r, wave_nxt;
  logic             managed, take, rel;
  logic [OWN_W-1:0] pid_m;
  logic [SIZE_W-1:0] fs_ext;

  always_comb begin
    managed = (IDX < int'(n_managed));
    pid_m   = wave_i.pid[OWN_W-1:0];
    fs_ext  = {{(SIZE_W-FS_W){1'b0}}, fs};
    take    = wave_i.vld && (wave_i.cmd == CMD_ALLOC) && managed && !taken_r &&
              (wave_i.rem != '0);
    rel     = wave_i.vld && (wave_i.cmd == CMD_FREE) && managed && taken_r &&
              (owner_r == pid_m);

    taken_nxt = taken_r;
    owner_nxt = owner_r;
    if (clr) begin
      taken_nxt = 1'b0;
    end else if (take) begin
      taken_nxt = 1'b1;
      owner_nxt = pid_m;
    end else if (rel) begin
      taken_nxt = 1'b0;
    end

    wave_nxt = wave_i;
    if (take) begin
      wave_nxt.rem = (wave_i.rem > fs_ext) ? (wave_i.rem - fs_ext) : '0;
    end
    wave_nxt.fcnt = wave_i.fcnt + {{(CNT_W-1){1'b0}}, (managed && !taken_nxt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r    <= 1'b0;
      wave_r.vld <= 1'b0;
    end else begin
      taken_r    <= taken_nxt;
      wave_r.vld <= wave_nxt.vld;
    end
    owner_r     <= owner_nxt;
    wave_r.cmd  <= wave_nxt.cmd;
    wave_r.pid  <= wave_nxt.pid;
    wave_r.rem  <= wave_nxt.rem;
    wave_r.fcnt <= wave_nxt.fcnt;
  end

  assign wave_o = wave_r;

endmodule

>>> rtl/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// First-fit page frame allocator built as a chain of frame cells.
//
// Each request item (allocate or release) gives one result item with ok and
// the free frame count. An allocate that cannot fit, that asks for size zero,
// or that finds no managed frames answers from S_CHECK through S_PUSH with no
// walk. Every other item sends an operation wave down the chain of NUM_FRAMES
// cells, one cell per cycle, and answers once the wave leaves the last cell.
// One item is worked on at a time; the next item is taken as soon as the
// result sits in the output register, even if it is not yet taken.
// Lowest-numbered free frames are granted first. Writing either register
// frees all frames at once and is taken in any cycle while idle. A frame size
// of 0 acts as 1; a frame count above NUM_FRAMES manages NUM_FRAMES.
// ----------------------------------------------------------------------------
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES = 64,
  parameter int PID_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pfa_in_if.sink     in_chan,
  pfa_out_if.source  out_chan,
  pfa_cfg_if.sink    cfg_chan
);

  // owner store never needs more bits than the pid port carries
  localparam int OWN_W = (PID_BITS < PID_W) ? PID_BITS : PID_W;
  // managed count after reset: min(64, NUM_FRAMES)
  localparam int RST_N = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;

  state_t state_r, state_nxt;

  // config
  logic [FS_W-1:0]  fs_r, fs_nxt;      // already forced to nonzero
  logic [CNT_W-1:0] n_r, n_nxt;        // already clamped to NUM_FRAMES
  logic [CNT_W-1:0] free_r, free_nxt;  // free managed frames
  logic             cfg_wr, tbl_clr;
  logic [CNT_W-1:0] cfg_n;

  // latched request
  logic              req_cmd_r;
  logic [PID_W-1:0]  req_pid_r;
  logic [SIZE_W-1:0] req_size_r;

  // pending result and output register
  logic             res_ok_r, res_ok_nxt;
  logic [CNT_W-1:0] res_free_r, res_free_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [CNT_W-1:0] out_free_r, out_free_nxt;

  // capacity of the free frames in allocation units
  logic [SIZE_W:0]  cap;

  // wave entering the first cell
  wave_t wave_head;
  wave_t chain [NUM_FRAMES+1];

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == S_IDLE);

  // config decode; writes must come only while idle, which the block does not enforce
  always_comb begin
    cfg_wr  = cfg_chan.valid && cfg_chan.ready;
    tbl_clr = 1'b0;
    fs_nxt  = fs_r;
    n_nxt   = n_r;
    cfg_n   = (int'(cfg_chan.data[CNT_W-1:0]) > NUM_FRAMES) ?
              CNT_W'(NUM_FRAMES) : cfg_chan.data[CNT_W-1:0];
    if (cfg_wr) begin
      unique case (cfg_chan.index)
        REG_FRAME_SIZE: begin
          fs_nxt  = (cfg_chan.data[FS_W-1:0] == '0) ? FS_W'(1) : cfg_chan.data[FS_W-1:0];
          tbl_clr = 1'b1;
        end
        REG_FRAMES_IN_USE: begin
          n_nxt   = cfg_n;
          tbl_clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign cap = (SIZE_W+1)'({{(SIZE_W+1-CNT_W){1'b0}}, free_r} *
                           {{(SIZE_W+1-FS_W){1'b0}}, fs_r});

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    free_nxt     = free_r;
    res_ok_nxt   = res_ok_r;
    res_free_nxt = res_free_r;
    out_vld_nxt  = out_vld_r && !out_chan.ready;
    out_ok_nxt   = out_ok_r;
    out_free_nxt = out_free_r;

    wave_head     = '0;
    wave_head.cmd = req_cmd_r;
    wave_head.pid = req_pid_r;
    wave_head.rem = req_size_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_free_nxt = free_r;
        if (req_cmd_r == CMD_ALLOC && n_r == '0) begin
          res_ok_nxt = 1'b0;
          state_nxt  = S_PUSH;
        end else if (req_cmd_r == CMD_ALLOC && req_size_r == '0) begin
          res_ok_nxt = 1'b1;
          state_nxt  = S_PUSH;
        end else if (req_cmd_r == CMD_ALLOC && {1'b0, req_size_r} > cap) begin
          res_ok_nxt = 1'b0;
          state_nxt  = S_PUSH;
        end else begin
          wave_head.vld = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (chain[NUM_FRAMES].vld) begin
          free_nxt     = chain[NUM_FRAMES].fcnt;
          res_ok_nxt   = 1'b1;
          res_free_nxt = chain[NUM_FRAMES].fcnt;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt  = 1'b1;
          out_ok_nxt   = res_ok_r;
          out_free_nxt = res_free_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a table rebuild frees every managed frame
    if (tbl_clr) begin
      free_nxt = n_nxt;
    end
  end

  assign chain[0] = wave_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      fs_r      <= FS_W'(4);
      n_r       <= CNT_W'(RST_N);
      free_r    <= CNT_W'(RST_N);
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      fs_r      <= fs_nxt;
      n_r       <= n_nxt;
      free_r    <= free_nxt;
    end
    res_ok_r   <= res_ok_nxt;
    res_free_r <= res_free_nxt;
    out_ok_r   <= out_ok_nxt;
    out_free_r <= out_free_nxt;
    if (in_chan.valid && in_chan.ready) begin
      req_cmd_r  <= in_chan.cmd;
      req_pid_r  <= in_chan.pid;
      req_size_r <= in_chan.size_needed;
    end
  end

  // frame table: one cell per frame, wave moves one cell per cycle
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    pfa_cell #(
      .IDX   (i),
      .OWN_W (OWN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clr       (tbl_clr),
      .n_managed (n_r),
      .fs        (fs_r),
      .wave_i    (chain[i]),
      .wave_o    (chain[i+1])
    );
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.free_frames = out_free_r;

endmodule

>>> test/page_frame_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_allocator_tb
// Self-checking bench for the first-fit page frame allocator. A local copy of
// the frame table predicts every reply; replies are matched in order against
// that copy. Directed items cover the edge cases, then random allocate and
// release traffic runs under several register settings, with random gaps on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module page_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int FRAME_COUNT = 64;
  localparam int ITEMS_PER_PHASE = 130;

  // Expected reply for one request item.
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] free_frames;
  } reply_t;

  logic clk;
  logic rst_n;

  pfa_in_if  in_bus ();
  pfa_out_if out_bus ();
  pfa_cfg_if cfg_bus ();

  page_frame_allocator #(
    .NUM_FRAMES(FRAME_COUNT),
    .PID_BITS  (PID_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .cfg_chan(cfg_bus)
  );

  // Local copy of the allocator state and its registers.
  logic [FS_W-1:0]  cfg_frame_size;
  logic [CNT_W-1:0] cfg_frame_count;
  logic             frame_busy [FRAME_COUNT];
  logic [PID_W-1:0] frame_pid  [FRAME_COUNT];

  reply_t           pending_replies[$];
  int               error_count = 0;
  bit               no_idle = 1'b0;    // suppress random gaps on both sides
  int               hold_off = 0;      // one-shot long stall for the receiver
  logic [PID_W-1:0] pid_pool[6];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #(64'd20_000_000);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  function automatic int managed_frames();
    return (cfg_frame_count > FRAME_COUNT) ? FRAME_COUNT : int'(cfg_frame_count);
  endfunction

  function automatic int free_frames_now();
    int c;
    c = 0;
    for (int i = 0; i < managed_frames(); i++)
      if (!frame_busy[i]) c++;
    return c;
  endfunction

  function automatic void clear_frames();
    for (int i = 0; i < FRAME_COUNT; i++) begin
      frame_busy[i] = 1'b0;
      frame_pid[i]  = '0;
    end
  endfunction

  // A write to either known register rebuilds the table; unknown indexes are dropped.
  function automatic void apply_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] value);
    if (idx == REG_FRAME_SIZE) begin
      cfg_frame_size = value[FS_W-1:0];
      clear_frames();
    end else if (idx == REG_FRAMES_IN_USE) begin
      cfg_frame_count = value[CNT_W-1:0];
      clear_frames();
    end
  endfunction

  // Updates the table for one request and returns the reply it must give.
  function automatic reply_t predict_reply(logic cmd, logic [PID_W-1:0] pid,
                                           logic [SIZE_W-1:0] size);
    reply_t r;
    int     n;
    int     freec;
    longint fs;
    longint need;
    longint got;
    n = managed_frames();
    r.ok = 1'b1;
    if (cmd == CMD_ALLOC) begin
      if (n == 0) begin
        r.ok = 1'b0;                   // nothing managed: refuse even size 0
      end else begin
        fs = (cfg_frame_size == 0) ? 1 : longint'(cfg_frame_size);
        need = (longint'(size) + fs - 1) / fs;
        if (free_frames_now() < need) begin
          r.ok = 1'b0;
        end else begin
          got = 0;                     // first fit: lowest free frames
          for (int i = 0; i < n && got < need; i++) begin
            if (!frame_busy[i]) begin
              frame_busy[i] = 1'b1;
              frame_pid[i]  = pid;
              got++;
            end
          end
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (frame_busy[i] && frame_pid[i] == pid) begin
          frame_busy[i] = 1'b0;
          frame_pid[i]  = '0;
        end
      end
    end
    freec = free_frames_now();
    if (freec > 127) freec = 127;
    r.free_frames = freec[CNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Channel helpers
  // --------------------------------------------------------------------------
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // One request item. Valid stays high into the next item when no gap is
  // drawn, so it is only lowered at the start of a gap.
  task automatic send_request(input logic cmd, input logic [PID_W-1:0] pid,
                              input logic [SIZE_W-1:0] size);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= cmd;
    in_bus.pid         <= pid;
    in_bus.size_needed <= size;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_replies.push_back(predict_reply(cmd, pid, size));
  endtask

  // Register writes only go out once every reply is back.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
    in_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    apply_register(idx, value);
  endtask

  // Sizes cluster around frame multiples so the table fills and drains.
  function automatic logic [SIZE_W-1:0] pick_size();
    longint fs;
    longint s;
    int     k;
    int     mode;
    fs = (cfg_frame_size == 0) ? 1 : longint'(cfg_frame_size);
    k = $urandom_range(1, 8);
    mode = $urandom_range(0, 99);
    if (mode < 10)
      s = 0;
    else if (mode < 70)
      s = k * fs - longint'($urandom_range(0, 1023)) % fs;
    else if (mode < 85)
      s = k * fs + $urandom_range(0, 1);
    else
      s = longint'($urandom() & 32'h007F_FFFF);
    if (s > 64'h7F_FFFF) s = 64'h7F_FFFF;
    return s[SIZE_W-1:0];
  endfunction

  task automatic send_random_item();
    logic [PID_W-1:0] pid;
    logic             cmd;
    pid = ($urandom_range(0, 99) < 85) ? pid_pool[$urandom_range(0, 5)]
                                       : PID_W'($urandom());
    cmd = ($urandom_range(0, 99) < 35) ? CMD_FREE : CMD_ALLOC;
    send_request(cmd, pid, pick_size());
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls per item, plus a one-shot long hold-off.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (hold_off > 0) begin
        stall = hold_off;
        hold_off = 0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  // Reply checker: every accepted item against the oldest expectation.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (out_bus.ok !== want.ok)
          report_mismatch($sformatf("ok got %b want %b", out_bus.ok, want.ok));
        if (out_bus.free_frames !== want.free_frames)
          report_mismatch($sformatf("free_frames got %0d want %0d",
                                    out_bus.free_frames, want.free_frames));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: frame size 4, all 64 frames managed.
  task automatic test_directed_alloc();
    send_request(CMD_ALLOC, 8'd1,   23'd0);        // zero size, no change
    send_request(CMD_ALLOC, 8'd1,   23'd1);
    send_request(CMD_ALLOC, 8'd2,   23'd4);        // exactly one frame
    send_request(CMD_ALLOC, 8'd3,   23'd5);        // rounds up to two
    send_request(CMD_ALLOC, 8'd4,   23'h7F_FFFF);  // far too big
    send_request(CMD_FREE,  8'd200, 23'd0);        // unknown pid
    send_request(CMD_FREE,  8'd2,   23'h7F_FFFF);  // size ignored on release
    send_request(CMD_ALLOC, 8'd255, 23'd240);      // fills the hole first
    send_request(CMD_ALLOC, 8'd0,   23'd8);        // one short: refused
    send_request(CMD_ALLOC, 8'd0,   23'd4);        // takes the last frame
    send_request(CMD_ALLOC, 8'd6,   23'd0);        // zero size on a full table
    send_request(CMD_FREE,  8'd255, 23'd0);
    send_request(CMD_FREE,  8'd1,   23'd0);
    send_request(CMD_FREE,  8'd3,   23'd0);
    send_request(CMD_FREE,  8'd0,   23'd0);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_FRAMES_IN_USE, 17'd0);           // nothing managed
    send_request(CMD_ALLOC, 8'd7, 23'd0);
    send_request(CMD_FREE,  8'd7, 23'd0);
    write_reg(REG_FRAMES_IN_USE, 17'h1_FFFF);      // masked to 127, clamps to 64
    write_reg(REG_FRAME_SIZE, 17'd0);              // acts as 1
    send_request(CMD_ALLOC, 8'd8, 23'd3);
    send_request(CMD_ALLOC, 8'd9, 23'd61);
    send_request(CMD_ALLOC, 8'd9, 23'd1);
    // unknown indexes must leave the table alone
    write_reg(8'd2, 17'd0);
    write_reg(8'hFF, 17'h1_FFFF);
    send_request(CMD_FREE,  8'd9, 23'd0);
    write_reg(REG_FRAME_SIZE, 17'h1_FFFF);
    send_request(CMD_ALLOC, 8'd10, 23'h7F_FFFF);   // needs 65 frames
    send_request(CMD_ALLOC, 8'd10, 23'd8388544);   // exactly 64
    write_reg(REG_FRAME_SIZE, 17'h1_0000);
    send_request(CMD_ALLOC, 8'd11, 23'd4194304);
    write_reg(REG_FRAMES_IN_USE, 17'd1);           // single frame
    send_request(CMD_ALLOC, 8'd12, 23'd65536);
    send_request(CMD_ALLOC, 8'd12, 23'd1);
  endtask

  task automatic test_random_traffic();
    logic [FS_W-1:0]  sizes [7];
    logic [CNT_W-1:0] counts[7];
    sizes  = '{17'd4, 17'd1, 17'd16, 17'h1_0000, 17'd3, 17'd1, 17'd0};
    counts = '{7'd64, 7'd64, 7'd8, 7'd64, 7'd33, 7'd1, 7'd127};
    sizes[5]  = FS_W'($urandom_range(1, 200));
    counts[5] = CNT_W'($urandom_range(1, 127));
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_FRAME_SIZE, CDATA_W'(sizes[p]));
      write_reg(REG_FRAMES_IN_USE, CDATA_W'(counts[p]));
      for (int i = 0; i < 6; i++) pid_pool[i] = PID_W'($urandom());
      no_idle = (p == 1 || p == 4);  // back-to-back phases
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // Receiver stalls long enough for the block to fill and block its input.
  task automatic test_backpressure();
    write_reg(REG_FRAME_SIZE, 17'd1);
    write_reg(REG_FRAMES_IN_USE, 17'd64);
    no_idle = 1'b1;
    hold_off = 300;
    for (int i = 0; i < 24; i++) send_random_item();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.cmd         <= CMD_ALLOC;
    in_bus.pid         <= '0;
    in_bus.size_needed <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= '0;
    cfg_bus.data       <= '0;
    cfg_frame_size  = FS_W'(4);
    cfg_frame_count = CNT_W'(64);
    clear_frames();
    for (int i = 0; i < 6; i++) pid_pool[i] = PID_W'(i);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_alloc();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    // drain, then give the block a full walk's worth of cycles to misbehave
    in_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (FRAME_COUNT + 8) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
